### sv/sha_pkg.sv
package sha_pkg;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
  } sha_item_t;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage

### sv/sha_fifo.sv
module sha_fifo
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_stall,
  input  sha_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_take,
  output sha_item_t rd_item
);
  localparam int Depth = 4;
  sha_item_t mem [Depth];
  logic [1:0] wptr, rptr;
  logic [2:0] fill;
  logic push, pop;

  assign wr_stall = (fill == 3'(Depth));
  assign rd_valid = (fill != 3'd0);
  assign rd_item  = mem[rptr];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_item;
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
  end
endmodule

### sv/sha_core.sv
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_take,
  input  sha_item_t   in_item,
  output logic        valid,
  input  logic        stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_LEN  = 6'b000100,
    S_RND  = 6'b001000,
    S_ADD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic [31:0] w [16];
  logic [31:0] h [8];
  logic [31:0] a, b, c, d, e, f, g, hh;
  logic [3:0]  widx;
  logic [63:0] bits;
  logic [5:0]  rnd;
  logic        final_blk;
  logic        pad_done;
  logic [2:0]  oidx;
  // length words were pushed in the block just compressed
  logic        len_sent;

  logic [31:0] keep, pad_word, s0, s1, wn, big0, big1, ch, maj, t1, t2, push_w;
  logic [2:0]  cnt;
  logic        push;
  logic [63:0] bits_new;

  assign cnt = (in_item.count > 3'd4) ? 3'd4 : in_item.count;
  assign in_take = (state == S_IDLE) && in_valid;

  always_comb begin
    case (cnt)
      3'd0: keep = 32'h0;
      3'd1: keep = 32'hff00_0000;
      3'd2: keep = 32'hffff_0000;
      3'd3: keep = 32'hffff_ff00;
      default: keep = 32'hffff_ffff;
    endcase
    pad_word = (in_item.word & keep) | (PAD_WORD >> {cnt, 3'b000});
    bits_new = in_item.last ? bits + {58'd0, cnt, 3'd0} : bits + 64'd32;
  end

  always_comb begin
    s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
    big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    ch  = (e & f) ^ (~e & g);
    maj = (a & b) ^ (a & c) ^ (b & c);
    t1  = hh + big1 + ch + round_k(rnd) + w[0];
    t2  = big0 + maj;
  end

  // one word into the block per cycle from the pad or length states, and from idle while a word is valid
  always_comb begin
    push = 1'b0;
    push_w = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        push = 1'b1;
        push_w = (in_item.last && cnt != 3'd4) ? pad_word : in_item.word;
      end
      S_PAD: begin
        push = 1'b1;
        push_w = pad_done ? 32'h0 : PAD_WORD;
      end
      S_LEN: begin
        push = 1'b1;
        push_w = (widx == 4'd14) ? bits[63:32] : bits[31:0];
      end
      default: ;
    endcase
  end

  assign valid       = (state == S_OUT);
  assign digest_word = h[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (push) w[widx] <= push_w;
    if (state == S_RND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      hh <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
    if (rst) begin
      state <= S_IDLE;
      widx <= '0;
      bits <= '0;
      rnd <= '0;
      final_blk <= 1'b0;
      pad_done <= 1'b0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
    end else begin
      if (push) widx <= widx + 4'd1;
      case (state)
        S_IDLE: if (in_valid) begin
          bits <= bits_new;
          if (in_item.last) begin
            final_blk <= 1'b1;
            pad_done <= (cnt != 3'd4);
          end
          if (widx == 4'd15) state <= S_RND;
          else if (in_item.last) state <= (cnt == 3'd4) ? S_PAD :
                                           (widx == 4'd13) ? S_LEN : S_PAD;
        end
        S_PAD: begin
          pad_done <= 1'b1;
          if (widx == 4'd15) state <= S_RND;
          else if (widx == 4'd13) state <= S_LEN;
        end
        S_LEN: if (widx == 4'd15) state <= S_RND;
        S_RND: ;
        S_ADD: ;
        S_OUT: ;
        default: state <= S_IDLE;
      endcase
      if (state == S_RND) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) state <= S_ADD;
      end
      if (state == S_ADD) begin
        h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c; h[3] <= h[3] + d;
        h[4] <= h[4] + e; h[5] <= h[5] + f; h[6] <= h[6] + g; h[7] <= h[7] + hh;
        if (!final_blk) state <= S_IDLE;
        else if (len_sent) state <= S_OUT;
        else state <= S_PAD;
      end
      if (state == S_OUT && !stall) begin
        oidx <= oidx + 3'd1;
        if (oidx == 3'd7) begin
          state <= S_IDLE;
          bits <= '0;
          final_blk <= 1'b0;
          pad_done <= 1'b0;
          for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
        end
      end
    end
    // load working registers as the block fills
    if (!rst && push && widx == 4'd15) begin
      a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3];
      e <= h[4]; f <= h[5]; g <= h[6]; hh <= h[7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (state == S_OUT && !stall && oidx == 3'd7)) len_sent <= 1'b0;
    else if (state == S_LEN && widx == 4'd15) len_sent <= 1'b1;
  end
endmodule

### sv/sha256_stream_hasher.sv
// SHA-256 stream hasher: words go through a 4-entry queue into the core.
// Each 16-word block is filled word by word, then compressed in 64 rounds and a final add into the hash;
// the round loop sets the rate, and the core takes no new words while it compresses.
// After the core takes the last word: padding/length fill and one or two compressions,
// then eight digest items, one per cycle when not stalled.
// Reset (rst, synchronous) loads the initial hash and empties the queue.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] message_word,
  input  logic [2:0]  byte_count,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  sha_item_t in_item, q_item;
  logic q_valid, q_take;

  assign in_item = {message_word, byte_count, is_last};

  // front: queue absorbs items while the core runs rounds
  sha_fifo u_fifo (
    .clk, .rst,
    .wr_valid(in_valid), .wr_stall(in_stall),
    .wr_item(in_item),
    .rd_valid(q_valid), .rd_take(q_take), .rd_item(q_item)
  );

  // back: block gather, padding, rounds and digest output
  sha_core u_core (
    .clk, .rst,
    .in_valid(q_valid), .in_take(q_take), .in_item(q_item),
    .valid(out_valid), .stall(out_stall),
    .digest_word, .word_index, .last_word
  );
endmodule
